// ----- design/slcc_pkg.sv -----
// ----------------------------------------------------------------------------
// slcc_pkg
// Shared widths, result types and saturating add for the segment list
// coalesce / compact block.
// ----------------------------------------------------------------------------
package slcc_pkg;

  localparam int ADDR_BITS = 16;
  localparam int PID_BITS  = 8;
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);

  localparam logic MODE_MERGE   = 1'b0;
  localparam logic MODE_COMPACT = 1'b1;

  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [PID_BITS-1:0]  pid_t;

  typedef struct packed {
    logic  hole;
    pid_t  pid;
    addr_t base;
    addr_t size;
    logic  last;
  } seg_res_t;

  // one queue entry: the results caused by one accepted item
  typedef struct packed {
    logic     two;
    seg_res_t r0;
    seg_res_t r1;
  } res_pair_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic addr_t sat_add(input addr_t a, input addr_t b);
    logic [ADDR_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[ADDR_BITS]) begin
      return {ADDR_BITS{1'b1}};
    end
    return s[ADDR_BITS-1:0];
  endfunction

endpackage

// ----- design/slcc_front.sv -----
// ----------------------------------------------------------------------------
// slcc_front
// Accepts segments, tracks the hole run / packing state and builds the
// results of each segment that causes any as one queue entry.
// ----------------------------------------------------------------------------
module slcc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                mode,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                is_hole,
  input  slcc_pkg::pid_t      process_id,
  input  slcc_pkg::addr_t     seg_base,
  input  slcc_pkg::addr_t     seg_size,
  input  logic                in_last,
  input  slcc_pkg::q_status_t q_status,
  output logic                push,
  output slcc_pkg::res_pair_t push_data
);
  import slcc_pkg::*;

  logic  hole_active, hole_active_next;
  addr_t hole_start, hole_start_next;
  addr_t hole_total, hole_total_next;
  logic  process_seen, process_seen_next;
  addr_t packed_end, packed_end_next;

  logic      accept;
  logic      emit;
  res_pair_t pair;
  addr_t     pb;
  addr_t     pe;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    hole_active_next  = hole_active;
    hole_start_next   = hole_start;
    hole_total_next   = hole_total;
    process_seen_next = process_seen;
    packed_end_next   = packed_end;
    emit              = 1'b0;
    pair              = '0;
    pb                = hole_active ? packed_end : seg_base;
    pe                = sat_add(pb, seg_size);

    if (is_hole) begin
      hole_active_next = 1'b1;
      if (!hole_active) begin
        hole_start_next = seg_base;
        hole_total_next = seg_size;
      end else begin
        hole_total_next = sat_add(hole_total, seg_size);
      end
      if (in_last) begin
        emit         = 1'b1;
        pair.r0.hole = 1'b1;
        pair.r0.base = (mode == MODE_COMPACT && process_seen) ? packed_end
                                                               : hole_start_next;
        pair.r0.size = hole_total_next;
        pair.r0.last = 1'b1;
      end
    end else if (mode == MODE_MERGE) begin
      emit = 1'b1;
      if (hole_active) begin
        // pending hole run goes out ahead of the process
        pair.two     = 1'b1;
        pair.r0.hole = 1'b1;
        pair.r0.base = hole_start;
        pair.r0.size = hole_total;
        pair.r1.pid  = process_id;
        pair.r1.base = seg_base;
        pair.r1.size = seg_size;
        pair.r1.last = in_last;
        hole_active_next = 1'b0;
        hole_total_next  = '0;
      end else begin
        pair.r0.pid  = process_id;
        pair.r0.base = seg_base;
        pair.r0.size = seg_size;
        pair.r0.last = in_last;
      end
    end else begin
      emit              = 1'b1;
      packed_end_next   = pe;
      process_seen_next = 1'b1;
      pair.r0.pid       = process_id;
      pair.r0.base      = pb;
      pair.r0.size      = seg_size;
      if (in_last && hole_active) begin
        // gathered hole follows the last process
        pair.two     = 1'b1;
        pair.r1.hole = 1'b1;
        pair.r1.base = pe;
        pair.r1.size = hole_total;
        pair.r1.last = 1'b1;
      end else begin
        pair.r0.last = in_last;
      end
    end

    if (in_last) begin
      hole_active_next  = 1'b0;
      hole_start_next   = '0;
      hole_total_next   = '0;
      process_seen_next = 1'b0;
      packed_end_next   = '0;
    end
  end

  assign push      = accept && emit;
  assign push_data = pair;

  always_ff @(posedge clk) begin
    if (rst) begin
      hole_active  <= 1'b0;
      hole_start   <= '0;
      hole_total   <= '0;
      process_seen <= 1'b0;
      packed_end   <= '0;
    end else if (accept) begin
      hole_active  <= hole_active_next;
      hole_start   <= hole_start_next;
      hole_total   <= hole_total_next;
      process_seen <= process_seen_next;
      packed_end   <= packed_end_next;
    end
  end

endmodule

// ----- design/slcc_fifo.sv -----
// ----------------------------------------------------------------------------
// slcc_fifo
// Short queue of result entries between the front and back parts.
// ----------------------------------------------------------------------------
module slcc_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  slcc_pkg::res_pair_t push_data,
  input  logic                pop,
  output slcc_pkg::res_pair_t head,
  output slcc_pkg::q_status_t status
);
  import slcc_pkg::*;

  res_pair_t                mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]       wr_ptr;
  logic [Q_PTR_W-1:0]       rd_ptr;
  logic [Q_PTR_W:0]         count;

  assign status.full  = (count == (Q_PTR_W+1)'(Q_DEPTH));
  assign status.empty = (count == '0);
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- design/slcc_back.sv -----
// ----------------------------------------------------------------------------
// slcc_back
// Drains entries one result per cycle into the output register unless stalled.
// ----------------------------------------------------------------------------
module slcc_back (
  input  logic                clk,
  input  logic                rst,
  input  slcc_pkg::res_pair_t head,
  input  slcc_pkg::q_status_t q_status,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_hole,
  output slcc_pkg::pid_t      out_process,
  output slcc_pkg::addr_t     out_base,
  output slcc_pkg::addr_t     out_size,
  output logic                out_last
);
  import slcc_pkg::*;

  logic     second;
  logic     load;
  seg_res_t cur;
  seg_res_t res;

  assign load = !q_status.empty && (!out_valid || out_ready);
  assign cur  = second ? head.r1 : head.r0;
  assign pop  = load && (second || !head.two);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      second    <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        second    <= !second && head.two;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= cur;
    end
  end

  assign out_hole    = res.hole;
  assign out_process = res.pid;
  assign out_base    = res.base;
  assign out_size    = res.size;
  assign out_last    = res.last;

endmodule

// ----- design/segment_list_coalesce_compact.sv -----
// ----------------------------------------------------------------------------
// segment_list_coalesce_compact
// Merges adjacent holes or compacts processes over an ordered segment list.
// ----------------------------------------------------------------------------
// channel  direction  handshake              payload
// cfg      in         cfg_valid / cfg_ready  cfg_data (mode)
// in       in         in_valid / in_ready    is_hole process_id seg_base
//                                            seg_size in_last
// out      out        out_valid / out_ready  out_hole out_process out_base
//                                            out_size out_last
//
// A segment is accepted every cycle while the four-entry result queue has
// room. Each result moves from the queue head into the output register,
// one result per cycle while out_ready is high, so a segment causing two
// results gives two outputs. rst clears the list state, the queue
// and mode. Output stalls fill the queue and then hold in_ready low.
// ----------------------------------------------------------------------------
module segment_list_coalesce_compact (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic            cfg_data,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            is_hole,
  input  slcc_pkg::pid_t  process_id,
  input  slcc_pkg::addr_t seg_base,
  input  slcc_pkg::addr_t seg_size,
  input  logic            in_last,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_hole,
  output slcc_pkg::pid_t  out_process,
  output slcc_pkg::addr_t out_base,
  output slcc_pkg::addr_t out_size,
  output logic            out_last
);
  import slcc_pkg::*;

  logic      mode;
  logic      push;
  logic      pop;
  res_pair_t push_data;
  res_pair_t head;
  q_status_t q_status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_MERGE;
    end else if (cfg_valid && cfg_ready) begin
      mode <= cfg_data;
    end
  end

  slcc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .mode       (mode),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .is_hole    (is_hole),
    .process_id (process_id),
    .seg_base   (seg_base),
    .seg_size   (seg_size),
    .in_last    (in_last),
    .q_status   (q_status),
    .push       (push),
    .push_data  (push_data)
  );

  slcc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  slcc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_status    (q_status),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_hole    (out_hole),
    .out_process (out_process),
    .out_base    (out_base),
    .out_size    (out_size),
    .out_last    (out_last)
  );

endmodule
